@@ hdl/fbfla_pkg.sv @@
// ---------------------------------------------------------------------------
// fbfla_pkg
// Types and constants shared by the fixed block free list allocator.
// ---------------------------------------------------------------------------
package fbfla_pkg;

   localparam int POOL_BLOCKS  = 256;
   localparam int CHUNK_BLOCKS = 5;
   localparam int IDX_W        = $clog2(POOL_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int ADDR_W       = 32;
   localparam int BSIZE_W      = 13;
   localparam int PROD_W       = IDX_W + BSIZE_W;

   localparam logic [CNT_W-1:0] POOL_COUNT  = CNT_W'(POOL_BLOCKS);
   localparam logic [CNT_W-1:0] CHUNK_COUNT = CNT_W'(CHUNK_BLOCKS);

   localparam logic       ACT_ALLOC = 1'b0;
   localparam logic       ACT_FREE  = 1'b1;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam logic       CSR_BASE_ADDRESS = 1'b0;
   localparam logic       CSR_BLOCK_SIZE   = 1'b1;

   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  granted_index;
      logic [ADDR_W-1:0] granted_address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic             last;
      logic [IDX_W-1:0] next;
   } link_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic fill;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic fill_todo;
   } stat_type;

endpackage

@@ hdl/fbfla_ctrl.sv @@
// ---------------------------------------------------------------------------
// fbfla_ctrl
// Two-state controller: takes a request, links a fresh chunk when one is
// carved, then commits once the result register can accept the outcome.
// ---------------------------------------------------------------------------
module fbfla_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fbfla_pkg::stat_type stat,
   output fbfla_pkg::cmd_type  cmd
);
   import fbfla_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.exec     = 1'b0;
      cmd.fill     = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            // link the blocks of a fresh chunk one per cycle first
            if (stat.fill_todo) begin
               cmd.fill = 1'b1;
            // hold the transaction while the previous result is still stalled
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_exec_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> !cmd.load_req)
      else $error("request taken in two consecutive cycles");

   a_exec_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> stat.out_free)
      else $error("commit while result register is busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec && cmd.load_req))
      else $error("commit and request load in the same cycle");

   a_fill_not_exec: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill && cmd.exec))
      else $error("link fill and commit in the same cycle");

endmodule

@@ hdl/fbfla_dp.sv @@
// ---------------------------------------------------------------------------
// fbfla_dp
// Datapath: config registers, free list head, carve counters, link memory
// and the result register.
// ---------------------------------------------------------------------------
module fbfla_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [31:0]         csr_write_data,
   input  fbfla_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fbfla_pkg::rsp_type  rsp_data,
   input  fbfla_pkg::cmd_type  cmd,
   output fbfla_pkg::stat_type stat
);
   import fbfla_pkg::*;

   logic [ADDR_W-1:0]  base_ff;
   logic [BSIZE_W-1:0] bsize_ff;
   req_type            req_ff;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic               head_valid_ff, head_valid_in;
   logic [CNT_W-1:0]   carved_ff, carved_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   link_type           link_rd_ff;
   link_type           link_mem [POOL_BLOCKS];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               link_we;
   link_type           link_wdata;
   logic [IDX_W-1:0]   fill_addr;
   link_type           fill_wdata;
   logic               carve;
   logic               fill_todo;
   logic [IDX_W-1:0]   grant;
   logic [1:0]         status;
   logic [CNT_W-1:0]   remain;
   logic [CNT_W-1:0]   chunk;
   logic [PROD_W-1:0]  offset;

   assign fill_todo = carve && (fill_ff < chunk);
   assign stat      = '{out_free: !rsp_valid_ff || !rsp_stall, fill_todo: fill_todo};

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bsize_ff <= BSIZE_W'(8);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_ff  <= csr_write_data;
            CSR_BLOCK_SIZE:   bsize_ff <= csr_write_data[BSIZE_W-1:0];
            default:          base_ff  <= base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // free, pop or carve: on a carve the first block of the chunk is granted,
   // the rest are linked in ascending order before the commit
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      carved_in     = carved_ff;
      link_we       = 1'b0;
      link_wdata    = '{last: !head_valid_ff, next: head_ff};
      carve         = 1'b0;
      grant         = '0;
      status        = ST_OK;
      remain        = POOL_COUNT - carved_ff;
      chunk         = (remain < CHUNK_COUNT) ? remain : CHUNK_COUNT;
      fill_addr     = carved_ff[IDX_W-1:0] + fill_ff[IDX_W-1:0];
      fill_wdata    = '{last: (fill_ff == chunk - CNT_W'(1)),
                        next: fill_addr + IDX_W'(1)};
      if (req_ff.action == ACT_FREE) begin
         if ({1'b0, req_ff.block_index} >= carved_ff) begin
            status = ST_BAD;
         end else begin
            link_we       = 1'b1;
            head_in       = req_ff.block_index;
            head_valid_in = 1'b1;
         end
      end else if (head_valid_ff) begin
         grant         = head_ff;
         head_valid_in = !link_rd_ff.last;
         head_in       = link_rd_ff.next;
      end else if (carved_ff == POOL_COUNT) begin
         status = ST_OOM;
      end else begin
         carve         = 1'b1;
         grant         = carved_ff[IDX_W-1:0];
         head_in       = carved_ff[IDX_W-1:0] + IDX_W'(1);
         head_valid_in = (chunk > CNT_W'(1));
         carved_in     = carved_ff + chunk;
      end
      offset = PROD_W'(grant) * PROD_W'(bsize_ff);
      rsp_in.granted_index   = grant;
      rsp_in.granted_address = (req_ff.action == ACT_ALLOC && status == ST_OK)
                               ? base_ff + ADDR_W'(offset) : '0;
      rsp_in.status          = status;
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.exec) begin
         fill_in = CNT_W'(1);
      end else if (cmd.fill) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         carved_ff     <= '0;
      end else if (cmd.exec) begin
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         carved_ff     <= carved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= CNT_W'(1);
      end else begin
         fill_ff <= fill_in;
      end
   end

   // link memory, read data registered
   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         link_mem[fill_addr] <= fill_wdata;
      end else if (cmd.exec && link_we) begin
         link_mem[req_ff.block_index] <= link_wdata;
      end
   end

   always_ff @(posedge clock) begin
      link_rd_ff <= link_mem[head_ff];
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_carve_bound: assert property (@(posedge clock) disable iff (reset)
      carved_ff <= POOL_COUNT)
      else $error("carve count past the pool");

   a_head_carved: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff |-> ({1'b0, head_ff} < carved_ff))
      else $error("list head names an uncarved block");

   a_fill_on_carve: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> carve)
      else $error("link fill outside a carve");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");

endmodule

@@ hdl/fixed_block_free_list_allocator.sv @@
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool with a LIFO free list kept in an internal memory.
// ---------------------------------------------------------------------------
// usage:
//   req_* channel carries one transaction: allocate (pop the list head,
//   carving the next chunk of blocks when the list is empty) or free (push
//   the given block). rsp_* returns one result per request: index, byte
//   address and status (ok, out_of_memory, bad_index).
//   csr_* writes base_address (index 0) or block_size (index 1); write only
//   while no transaction is in flight.
//   a taken request is registered; its result is written to the result
//   register when it commits. a new request is taken only after the last
//   one commits; the link memory read at the list head is registered.
//   an allocate that carves a chunk first links the new blocks after the
//   granted one, one per cycle, before it commits.
//   reset empties the list, clears the carve count and restores base 0,
//   block size 8; the link memory is not cleared.
//   a stalled result holds; one further request may be taken and waits
//   until the result register is free.
// ---------------------------------------------------------------------------
module fixed_block_free_list_allocator (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  fbfla_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fbfla_pkg::rsp_type rsp_data
);
   import fbfla_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fbfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbfla_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
